// File: sv/csq_pkg.sv
// ============================================================================
// csq_pkg
// Shared constants and codes for the counting semaphore wait queue.
// ============================================================================
`default_nettype none

package csq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;
    localparam int MAX_RESULTS     = 16;

    localparam int FUNC_W   = 2;
    localparam int TID_W    = 8;
    localparam int ACT_W    = 3;
    localparam int RID_W    = 8;
    localparam int INIT_W   = 15;
    localparam int COUNT_W  = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
    localparam logic [INIT_W-1:0] INIT_RESET = 15'd1;

    // Operation codes on the input beat.
    localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd2;

    // Result codes on the output beat.
    localparam logic [ACT_W-1:0] ACT_CONTINUE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BLOCKED  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OVERFLOW = 3'd4;

    // Register index of initial_count.
    localparam logic REG_INITIAL_COUNT = 1'b0;

endpackage

`default_nettype wire

// File: sv/csq_ram.sv
// ============================================================================
// csq_ram
// Simple dual-port RAM with one write port and a registered read port.
// ============================================================================
`default_nettype none

module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/counting_semaphore_wait_queue_top.sv
// ============================================================================
// counting_semaphore_wait_queue_top
// Hardware counting semaphore with a FIFO of blocked thread ids.
// ============================================================================
// Each input beat carries one operation. A wait decrements the count and,
// when the count goes negative, queues the caller's id and answers "blocked"
// (or "overflow" if the queue is full, leaving the count alone). A signal
// increments the count (saturating at 32767) and, when the count is still at
// or below zero, releases the oldest waiter, or answers "nothing released"
// if the queue is empty. A close releases queued waiters oldest first, one
// output beat each, at most MAX_RESULTS per close, with tlast on the final
// beat; once the queue is empty the pointers are cleared and the count is
// reloaded from initial_count. Every other operation gives exactly one beat
// with tlast set. Waits, signals that release nothing, unused codes and
// closes on an empty queue are answered straight from the idle state. A
// releasing signal or a close takes no new beat until its releases are
// out, because every release reads the wait store through its registered
// read port (a fetch state reads the head entry, an emit state sends it). The output
// is registered, so a new beat is taken while the previous result is being
// drained by the sink. The wait store has no clearing pass after reset.
// ============================================================================
`default_nettype none

module counting_semaphore_wait_queue_top
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Input stream: tdata from bit 0 up: func[1:0], thread_id[9:2], zero pad[15:10]
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // Result stream: tdata from bit 0 up: action[2:0], released_id[10:3],
    // zero pad[15:11]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tlast,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready
);

    // Pointer and fill widths follow the queue depth.
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    // Only the low bits of the 8-bit id field survive the id mask.
    localparam int SW    = (ID_BITS < TID_W) ? ID_BITS : TID_W;
    localparam int DRN_W = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [INIT_W-1:0] init_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INITIAL_COUNT);
    assign prdata = (paddr[2] == REG_INITIAL_COUNT) ?
                    APB_DW'(init_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= INIT_RESET;
        end else if (cfg_wr) begin
            init_reg <= pwdata[INIT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [FUNC_W-1:0] in_func;
    logic [TID_W-1:0]  in_tid;

    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_tid  = s_tdata[FUNC_W +: TID_W];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0]          head_reg, head_next;
    logic [PTR_W-1:0]          tail_reg, tail_next;
    logic [OCC_W-1:0]          occ_reg, occ_next;
    logic                      close_reg, close_next;   // draining for a close
    logic [DRN_W-1:0]          drn_reg, drn_next;       // beats sent this close

    logic                      out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]          out_act_reg, out_act_next;
    logic [RID_W-1:0]          out_rid_reg, out_rid_next;
    logic                      out_last_reg, out_last_next;

    // Wait store: written on a blocking wait, read at the head pointer.
    logic             mem_we;
    logic [SW-1:0]    mem_wdata;
    logic [SW-1:0]    mem_rdata;

    assign mem_wdata = SW'(in_tid);

    csq_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (tail_reg),
        .wdata (mem_wdata),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    // The output register is free when empty or being taken this cycle.
    logic out_free;
    logic accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_rid_reg, out_act_reg});
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [COUNT_W-1:0] dec_cnt;
        logic signed [COUNT_W-1:0] inc_cnt;
        logic                      q_full;
        logic                      q_empty;
        logic                      last_pop;
        logic                      fin;

        dec_cnt  = (count_reg != COUNT_MIN) ? count_reg - 16'sd1 : count_reg;
        inc_cnt  = (count_reg != COUNT_MAX) ? count_reg + 16'sd1 : count_reg;
        q_full   = (occ_reg == OCC_W'(QUEUE_DEPTH));
        q_empty  = (occ_reg == '0);
        last_pop = (occ_reg == OCC_W'(1));
        fin      = last_pop || (drn_reg == DRN_W'(MAX_RESULTS - 1));

        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        close_next     = close_reg;
        drn_next       = drn_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_act_next   = out_act_reg;
        out_rid_next   = out_rid_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // Most operations answer at once with a single beat.
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_CONTINUE;
                    out_rid_next   = '0;
                    out_last_next  = 1'b1;
                    case (in_func)
                        FUNC_WAIT: begin
                            if (dec_cnt < 0) begin
                                if (q_full) begin
                                    out_act_next = ACT_OVERFLOW;
                                end else begin
                                    mem_we       = 1'b1;
                                    tail_next    = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                   '0 : tail_reg + 1'b1;
                                    occ_next     = occ_reg + 1'b1;
                                    count_next   = dec_cnt;
                                    out_act_next = ACT_BLOCKED;
                                end
                            end else begin
                                count_next = dec_cnt;
                            end
                        end
                        FUNC_SIGNAL: begin
                            count_next = inc_cnt;
                            if (inc_cnt <= 0) begin
                                if (q_empty) begin
                                    out_act_next = ACT_NONE;
                                end else begin
                                    out_valid_next = out_valid_reg && !m_tready;
                                    close_next     = 1'b0;
                                    state_next     = ST_FETCH;
                                end
                            end
                        end
                        FUNC_CLOSE: begin
                            if (q_empty) begin
                                out_act_next = ACT_NONE;
                                head_next    = '0;
                                tail_next    = '0;
                                count_next   = COUNT_W'(init_reg);
                            end else begin
                                out_valid_next = out_valid_reg && !m_tready;
                                close_next     = 1'b1;
                                drn_next       = '0;
                                state_next     = ST_FETCH;
                            end
                        end
                        default: begin
                            // Unused code: answered as continue.
                        end
                    endcase
                end
            end

            ST_FETCH: begin
                // Head entry is captured by the store's read register here.
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_act_next   = ACT_RELEASED;
                    out_rid_next   = RID_W'(mem_rdata);
                    out_last_next  = close_reg ? fin : 1'b1;
                    head_next      = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : head_reg + 1'b1;
                    occ_next       = occ_reg - 1'b1;
                    drn_next       = drn_reg + 1'b1;
                    if (close_reg && last_pop) begin
                        // Queue drained: reopen the semaphore.
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = COUNT_W'(init_reg);
                    end
                    state_next = (close_reg && !fin) ? ST_FETCH : ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_W'(INIT_RESET);
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            close_reg     <= 1'b0;
            drn_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            close_reg     <= close_next;
            drn_reg       <= drn_next;
            out_valid_reg <= out_valid_next;
        end
        out_act_reg  <= out_act_next;
        out_rid_reg  <= out_rid_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// File: sv/csq_checker.sv
// ============================================================================
// csq_checker
// Port-level assertions for the counting semaphore wait queue.
// ============================================================================
`default_nettype none

module csq_checker
    import csq_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tlast
);

    logic [ACT_W-1:0] act;
    logic [RID_W-1:0] rid;

    assign act = m_tdata[ACT_W-1:0];
    assign rid = m_tdata[ACT_W +: RID_W];

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Input is only taken when the output register can take the answer.
    a_in_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while result register is blocked");

    // Only a release carries an id.
    a_rid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && act != ACT_RELEASED |-> rid == '0)
        else $error("released id set on a non-release beat");

    // Only releases can belong to a multi-beat close.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && act != ACT_RELEASED |-> m_tlast)
        else $error("non-release beat without tlast");

endmodule

bind counting_semaphore_wait_queue_top csq_checker u_csq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/tb_counting_semaphore_wait_queue_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_counting_semaphore_wait_queue_top
// Self-checking bench for the counting semaphore with a FIFO wait queue.
// ============================================================================
// A queue of operations feeds a clocked driver on the input stream. Every
// accepted beat runs through a predictor of the semaphore that holds its own
// count, wait store and pointers and queues the result beats it expects. A
// clocked monitor takes the result stream and compares each beat, field by
// field, with the oldest expected beat. A directed opening fills the wait
// queue, overflows it, releases from it and closes it. Random segments
// follow, each after a new initial_count has been written and loaded by a
// close. Both sides throttle at random, in three idle patterns.
// ============================================================================

module tb_counting_semaphore_wait_queue_top;
    import csq_pkg::*;

    localparam int                QDEPTH          = DEF_QUEUE_DEPTH;
    localparam int                STALL_LIMIT     = 5000;
    localparam int                SEGMENT_OPS     = 75;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED     = 2'd3;
    localparam logic [APB_AW-1:0] INIT_COUNT_ADDR = APB_AW'(4 * int'(REG_INITIAL_COUNT));

    // One operation waiting to be sent. A set hold_for_drain makes the driver
    // wait until every expected result beat has come back before sending it.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TID_W-1:0]  tid;
        logic              hold_for_drain;
    } sem_op_t;

    // One result beat as the semaphore should produce it.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [RID_W-1:0] rid;
        logic             last;
    } sem_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // Fields from bit 0 up: func[1:0], thread_id[9:2], zero pad[15:10].
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // Fields from bit 0 up: action[2:0], released_id[10:3], zero pad[15:11].
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    counting_semaphore_wait_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Operations still to be sent, and result beats still to be received.
    sem_op_t     op_queue[$];
    sem_result_t due_results[$];

    // Idle chances in percent per cycle, changed only between segments.
    int unsigned sender_idle_pct = 0;
    int unsigned sink_idle_pct   = 0;
    int          mismatch_count  = 0;
    int          stall_cycles    = 0;

    // Predictor state: the semaphore as the block should hold it.
    logic signed [COUNT_W-1:0] sem_count;
    logic        [INIT_W-1:0]  init_count;
    logic        [TID_W-1:0]   waiter_ids[QDEPTH];
    int                        head_idx;
    int                        tail_idx;
    int                        waiting;

    function automatic sem_result_t make_result(logic [ACT_W-1:0] action,
                                                logic [RID_W-1:0] rid, logic last);
        sem_result_t r;
        r.action = action;
        r.rid    = rid;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [TID_W-1:0] pop_waiter();
        logic [TID_W-1:0] id;
        id       = waiter_ids[head_idx];
        head_idx = (head_idx + 1) % QDEPTH;
        waiting--;
        return id;
    endfunction

    // Applies one operation to the predicted semaphore and queues the result
    // beats it must cause.
    task automatic apply_semaphore_op(logic [FUNC_W-1:0] func, logic [TID_W-1:0] tid);
        logic signed [COUNT_W-1:0] next_count;
        logic        [TID_W-1:0]   id;
        int                        n;
        case (func)
            FUNC_WAIT: begin
                next_count = (sem_count > COUNT_MIN) ? sem_count - 16'sd1 : COUNT_MIN;
                if (next_count < 16'sd0) begin
                    if (waiting >= QDEPTH) begin
                        // A full queue turns the caller away and keeps the count.
                        due_results.push_back(make_result(ACT_OVERFLOW, '0, 1'b1));
                    end else begin
                        waiter_ids[tail_idx] = tid;
                        tail_idx = (tail_idx + 1) % QDEPTH;
                        waiting++;
                        sem_count = next_count;
                        due_results.push_back(make_result(ACT_BLOCKED, '0, 1'b1));
                    end
                end else begin
                    sem_count = next_count;
                    due_results.push_back(make_result(ACT_CONTINUE, '0, 1'b1));
                end
            end
            FUNC_SIGNAL: begin
                if (sem_count < COUNT_MAX) sem_count = sem_count + 16'sd1;
                if (sem_count <= 16'sd0) begin
                    if (waiting == 0) begin
                        due_results.push_back(make_result(ACT_NONE, '0, 1'b1));
                    end else begin
                        id = pop_waiter();
                        due_results.push_back(make_result(ACT_RELEASED, id, 1'b1));
                    end
                end else begin
                    due_results.push_back(make_result(ACT_CONTINUE, '0, 1'b1));
                end
            end
            FUNC_CLOSE: begin
                n = 0;
                if (waiting == 0) begin
                    due_results.push_back(make_result(ACT_NONE, '0, 1'b1));
                end else begin
                    while (waiting > 0 && n < MAX_RESULTS) begin
                        id = pop_waiter();
                        due_results.push_back(make_result(ACT_RELEASED, id,
                            (waiting == 0) || (n + 1 == MAX_RESULTS)));
                        n++;
                    end
                end
                // An emptied queue reopens the semaphore with a fresh count.
                if (waiting == 0) begin
                    head_idx  = 0;
                    tail_idx  = 0;
                    sem_count = signed'({1'b0, init_count});
                end
            end
            default: begin
                due_results.push_back(make_result(ACT_CONTINUE, '0, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver. The beat on the bus is predicted at the edge that accepts it;
    // a new beat is only offered when the bus is free or just drained.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_semaphore_op(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W +: TID_W]);
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0
                        && !(op_queue[0].hold_for_drain && due_results.size() != 0)
                        && $urandom_range(99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'({op_queue[0].tid, op_queue[0].func});
                    void'(op_queue.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result beat is held against the oldest one due.
    always @(posedge aclk) begin
        sem_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $display("[%0t] result beat with nothing expected: action %0d id %0d",
                             $realtime, m_tdata[ACT_W-1:0], m_tdata[ACT_W +: RID_W]);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[ACT_W-1:0] !== want.action)
                        report_mismatch("action", m_tdata[ACT_W-1:0], want.action);
                    if (m_tdata[ACT_W +: RID_W] !== want.rid)
                        report_mismatch("released_id", m_tdata[ACT_W +: RID_W], want.rid);
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", m_tlast, want.last);
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog. It counts cycles in which work is outstanding but no beat
    // moves on either stream.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (!s_tvalid && op_queue.size() == 0 && due_results.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_op(logic [FUNC_W-1:0] func, logic [TID_W-1:0] tid, logic hold);
        sem_op_t op;
        op.func           = func;
        op.tid            = tid;
        op.hold_for_drain = hold;
        op_queue.push_back(op);
    endtask

    // Mostly waits and signals in near balance, so that the queue fills and
    // drains, with closes now and then and a few unused codes.
    task automatic push_random_op();
        int unsigned pick;
        logic [FUNC_W-1:0] func;
        pick = $urandom_range(99);
        if (pick < 46)      func = FUNC_WAIT;
        else if (pick < 88) func = FUNC_SIGNAL;
        else if (pick < 96) func = FUNC_CLOSE;
        else                func = FUNC_UNUSED;
        push_op(func, TID_W'($urandom_range(255)), 1'b0);
    endtask

    // Returns once every operation is sent and every result beat has come,
    // and then waits for the block to settle.
    task automatic wait_drained();
        do @(negedge aclk);
        while (op_queue.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_initial_count(logic [INIT_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INIT_COUNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        init_count = value;
    endtask

    initial begin
        logic [INIT_W-1:0] seg_init;
        sem_count  = signed'({1'b0, INIT_RESET});
        init_count = INIT_RESET;
        head_idx   = 0;
        tail_idx   = 0;
        waiting    = 0;

        sender_idle_pct = 33;
        sink_idle_pct   = 71;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening on the reset count of one. The first wait takes
        // the count to zero, the next sixteen fill the wait queue with the
        // extreme ids first, and one more finds the queue full.
        push_op(FUNC_WAIT, 8'h00, 1'b0);
        push_op(FUNC_WAIT, 8'hFF, 1'b0);
        push_op(FUNC_WAIT, 8'hAA, 1'b0);
        push_op(FUNC_WAIT, 8'h55, 1'b0);
        for (int i = 0; i < QDEPTH - 3; i++)
            push_op(FUNC_WAIT, TID_W'($urandom_range(255)), 1'b0);
        push_op(FUNC_WAIT, 8'h3C, 1'b0);
        // Two releases, the second only after the sender has let all
        // outstanding results come back.
        push_op(FUNC_SIGNAL, 8'hFF, 1'b0);
        push_op(FUNC_SIGNAL, 8'h00, 1'b1);
        // A close on a long queue, then one on an empty queue.
        push_op(FUNC_CLOSE, 8'h00, 1'b0);
        push_op(FUNC_CLOSE, 8'hFF, 1'b0);
        push_op(FUNC_UNUSED, 8'hFF, 1'b0);
        push_op(FUNC_SIGNAL, 8'h00, 1'b0);
        push_op(FUNC_WAIT, 8'h81, 1'b0);
        wait_drained();

        // Random segments. Each writes a new initial_count while the block is
        // idle and starts with a close, which loads it. The second segment
        // starts at the top of the count range, so its first signal saturates.
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       seg_init = '0;
                1:       seg_init = '1;
                2:       seg_init = INIT_W'($urandom_range(4, 1));
                3:       seg_init = INIT_W'($urandom_range(32767));
                4:       seg_init = INIT_W'(2);
                default: seg_init = INIT_W'(1);
            endcase
            if (seg < 2) begin
                sender_idle_pct = 33;
                sink_idle_pct   = 71;
            end else if (seg < 4) begin
                sender_idle_pct = 71;
                sink_idle_pct   = 33;
            end else begin
                sender_idle_pct = 0;
                sink_idle_pct   = 0;
            end
            write_initial_count(seg_init);
            @(negedge aclk);
            push_op(FUNC_CLOSE, TID_W'($urandom_range(255)), 1'b0);
            if (seg == 1)
                push_op(FUNC_SIGNAL, TID_W'($urandom_range(255)), 1'b0);
            for (int i = 0; i < SEGMENT_OPS; i++)
                push_random_op();
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        if (due_results.size() != 0) begin
            $display("%0d result beats never arrived", due_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
